>>> rtl/assert_macros.svh
// Assertion macros shared by the map core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SOM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SOM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/som_pkg.sv
// Shared types and constants of the map core.
package som_pkg;

	localparam int WORD_W = 16;
	localparam int VEC_W  = 64;
	localparam int DIST_W = 34;
	localparam int SQ_W   = 33;
	localparam int IDX_W  = 6;

	localparam logic [2:0] FN_LOAD  = 3'd0;
	localparam logic [2:0] FN_TRAIN = 3'd1;
	localparam logic [2:0] FN_LABEL = 3'd2;
	localparam logic [2:0] FN_READ  = 3'd3;
	localparam logic [2:0] FN_CLEAR = 3'd4;

	localparam logic [1:0] CFG_RATE_BASE   = 2'd0;
	localparam logic [1:0] CFG_EPOCH_COUNT = 2'd1;
	localparam logic [1:0] CFG_RADIUS      = 2'd2;

	typedef struct packed {
		logic rd_en;
		logic srch;
		logic upd;
		logic ld_en;
		logic lab_en;
		logic clr;
		logic first;
	} cell_ctl_t;

	typedef struct packed {
		logic              v;
		logic [DIST_W-1:0] d;
		logic [IDX_W-1:0]  r;
		logic [IDX_W-1:0]  c;
	} chain_t;

endpackage

>>> rtl/som_bmu_search_and_update_core.sv
// Top level of the map core: command sequencer, configuration, column chain.
// Load/read: fetch through ST_FETCH, ST_FWAIT and ST_FOUT, or done straight from idle if out of range.
// Clear and unused codes: done straight from idle. Label: row search, min chain drain, fetch.
// Train: also waits on the rate divider, then sweeps the clipped rows, drains and fetches.
// One request at a time; results never stall.
// Reset clears configuration to defaults and all labels; weights stay unknown until loaded.
module som_bmu_search_and_update_core import som_pkg::*; #(
	parameter int GRID_ROWS = 8,
	parameter int GRID_COLS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [15:0]       cfg_wdata,
	input  logic [2:0]        func,
	input  logic [15:0]       x0,
	input  logic [15:0]       x1,
	input  logic [15:0]       x2,
	input  logic [15:0]       x3,
	input  logic [15:0]       epoch,
	input  logic [2:0]        cell_row,
	input  logic [3:0]        cell_col,
	input  logic [1:0]        class_id,
	output logic [2:0]        bmu_row,
	output logic [3:0]        bmu_col,
	output logic [33:0]       best_dist_sq,
	output logic [1:0]        cell_label,
	output logic [15:0]       w0,
	output logic [15:0]       w1,
	output logic [15:0]       w2,
	output logic [15:0]       w3
);
	`include "assert_macros.svh"

	localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int CNT_W = $clog2(GRID_ROWS + GRID_COLS + 8);

	typedef enum logic [3:0] {
		ST_IDLE, ST_FETCH, ST_FWAIT, ST_FOUT, ST_SRCH, ST_SDRAIN,
		ST_RATE, ST_UPD, ST_UDRAIN
	} state_t;

	state_t            state_q;
	cell_ctl_t         ctl_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [2:0]        func_q;
	logic [VEC_W-1:0]  x_q;
	logic [2:0]        row_raw_q;
	logic [3:0]        col_raw_q;
	logic [1:0]        cls_q;
	logic [RW-1:0]     row_idx_q, rd_row_q, wr_row_q, br_q, row_lo_q, row_hi_q;
	logic [CW-1:0]     sel_col_q, bc_q, col_lo_q, col_hi_q;
	logic [DIST_W-1:0] dist_q;
	logic              done_q;
	logic [2:0]        bmu_row_q;
	logic [3:0]        bmu_col_q;
	logic [DIST_W-1:0] dist_out_q;
	logic [1:0]        lab_out_q;
	logic [VEC_W-1:0]  w_out_q;
	logic [15:0]       rate_base_q, epoch_count_q;
	logic [3:0]        radius_q;
	logic [15:0]       rate;
	logic              div_done, div_start, in_rng, search_fn, upd_row_ok;
	chain_t            ch [GRID_COLS+1];
	logic [VEC_W-1:0]  cell_rdata [GRID_COLS];
	logic [1:0]        cell_rlab [GRID_COLS];
	logic signed [IDX_W+1:0] r_lo_s, r_hi_s, c_lo_s, c_hi_s;
	logic [RW-1:0]     row_lo, row_hi;
	logic [CW-1:0]     col_lo, col_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_base_q   <= 16'd58982;
			epoch_count_q <= 16'd500;
			radius_q      <= 4'd3;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_RATE_BASE:   rate_base_q   <= cfg_wdata;
				CFG_EPOCH_COUNT: epoch_count_q <= cfg_wdata;
				CFG_RADIUS:      radius_q      <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign in_rng     = (32'(cell_row) < GRID_ROWS) && (32'(cell_col) < GRID_COLS);
	assign div_start  = start && !busy && (func == FN_TRAIN);
	assign search_fn  = (func_q == FN_TRAIN) || (func_q == FN_LABEL);
	assign upd_row_ok = (RW'(cnt_q) >= row_lo_q) && (RW'(cnt_q) <= row_hi_q);

	som_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.base   (rate_base_q),
		.ecount (epoch_count_q),
		.epoch  (epoch),
		.rate   (rate),
		.done   (div_done)
	);

	assign ch[0] = '0;

	for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
		som_cell #(
			.ROWS (GRID_ROWS),
			.RW   (RW),
			.CW   (CW),
			.COL  (c)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl_q),
			.rd_row  (rd_row_q),
			.wr_row  (wr_row_q),
			.sel_col (sel_col_q),
			.col_lo  (col_lo_q),
			.col_hi  (col_hi_q),
			.x       (x_q),
			.rate    (rate),
			.cls     (cls_q),
			.ch_in   (ch[c]),
			.ch_out  (ch[c+1]),
			.rdata   (cell_rdata[c]),
			.rlab    (cell_rlab[c])
		);
	end

	always_comb begin
		r_lo_s = $signed({2'b00, ch[GRID_COLS].r}) - $signed({4'b0000, radius_q});
		r_hi_s = $signed({2'b00, ch[GRID_COLS].r}) + $signed({4'b0000, radius_q});
		c_lo_s = $signed({2'b00, ch[GRID_COLS].c}) - $signed({4'b0000, radius_q});
		c_hi_s = $signed({2'b00, ch[GRID_COLS].c}) + $signed({4'b0000, radius_q});
		row_lo = (r_lo_s < 0) ? '0 : RW'(r_lo_s);
		row_hi = (r_hi_s > GRID_ROWS - 1) ? RW'(GRID_ROWS - 1) : RW'(r_hi_s);
		col_lo = (c_lo_s < 0) ? '0 : CW'(c_lo_s);
		col_hi = (c_hi_s > GRID_COLS - 1) ? CW'(GRID_COLS - 1) : CW'(c_hi_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ctl_q      <= '0;
			cnt_q      <= '0;
			done_q     <= 1'b0;
			func_q     <= '0;
			x_q        <= '0;
			row_raw_q  <= '0;
			col_raw_q  <= '0;
			cls_q      <= '0;
			row_idx_q  <= '0;
			rd_row_q   <= '0;
			wr_row_q   <= '0;
			br_q       <= '0;
			row_lo_q   <= '0;
			row_hi_q   <= '0;
			sel_col_q  <= '0;
			bc_q       <= '0;
			col_lo_q   <= '0;
			col_hi_q   <= '0;
			dist_q     <= '0;
			bmu_row_q  <= '0;
			bmu_col_q  <= '0;
			dist_out_q <= '0;
			lab_out_q  <= '0;
			w_out_q    <= '0;
		end else begin
			ctl_q  <= '0;
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						func_q    <= func;
						x_q       <= {x3, x2, x1, x0};
						row_raw_q <= cell_row;
						col_raw_q <= cell_col;
						cls_q     <= class_id;
						row_idx_q <= RW'(cell_row);
						wr_row_q  <= RW'(cell_row);
						sel_col_q <= CW'(cell_col);
						case (func)
							FN_LOAD, FN_READ: begin
								if (in_rng) begin
									ctl_q.ld_en <= (func == FN_LOAD);
									state_q     <= ST_FETCH;
								end else begin
									bmu_row_q  <= cell_row;
									bmu_col_q  <= cell_col;
									dist_out_q <= '0;
									lab_out_q  <= '0;
									w_out_q    <= '0;
									done_q     <= 1'b1;
								end
							end
							FN_TRAIN, FN_LABEL: begin
								ctl_q.first <= 1'b1;
								cnt_q       <= '0;
								state_q     <= ST_SRCH;
							end
							default: begin
								ctl_q.clr  <= (func == FN_CLEAR);
								bmu_row_q  <= '0;
								bmu_col_q  <= '0;
								dist_out_q <= '0;
								lab_out_q  <= '0;
								w_out_q    <= '0;
								done_q     <= 1'b1;
							end
						endcase
					end
				end
				ST_FETCH: begin
					ctl_q.rd_en <= 1'b1;
					rd_row_q    <= row_idx_q;
					state_q     <= ST_FWAIT;
				end
				ST_FWAIT: begin
					state_q <= ST_FOUT;
				end
				ST_FOUT: begin
					bmu_row_q  <= search_fn ? 3'(br_q) : row_raw_q;
					bmu_col_q  <= search_fn ? 4'(bc_q) : col_raw_q;
					dist_out_q <= search_fn ? dist_q : '0;
					lab_out_q  <= cell_rlab[sel_col_q];
					w_out_q    <= cell_rdata[sel_col_q];
					done_q     <= 1'b1;
					state_q    <= ST_IDLE;
				end
				ST_SRCH: begin
					ctl_q.rd_en <= 1'b1;
					ctl_q.srch  <= 1'b1;
					rd_row_q    <= RW'(cnt_q);
					if (cnt_q == CNT_W'(GRID_ROWS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SDRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SDRAIN: begin
					if (cnt_q == CNT_W'(GRID_COLS + 6)) begin
						br_q      <= RW'(ch[GRID_COLS].r);
						bc_q      <= CW'(ch[GRID_COLS].c);
						dist_q    <= ch[GRID_COLS].d;
						row_idx_q <= RW'(ch[GRID_COLS].r);
						wr_row_q  <= RW'(ch[GRID_COLS].r);
						sel_col_q <= CW'(ch[GRID_COLS].c);
						row_lo_q  <= row_lo;
						row_hi_q  <= row_hi;
						col_lo_q  <= col_lo;
						col_hi_q  <= col_hi;
						cnt_q     <= '0;
						if (func_q == FN_LABEL) begin
							ctl_q.lab_en <= 1'b1;
							state_q      <= ST_FETCH;
						end else begin
							state_q <= ST_RATE;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RATE: begin
					if (div_done) begin
						cnt_q   <= CNT_W'(row_lo_q);
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					ctl_q.rd_en <= 1'b1;
					ctl_q.upd   <= 1'b1;
					rd_row_q    <= RW'(cnt_q);
					if (RW'(cnt_q) == row_hi_q) begin
						cnt_q   <= '0;
						state_q <= ST_UDRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_UDRAIN: begin
					if (cnt_q == CNT_W'(3)) begin
						cnt_q   <= '0;
						state_q <= ST_FETCH;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done         = done_q;
	assign bmu_row      = bmu_row_q;
	assign bmu_col      = bmu_col_q;
	assign best_dist_sq = dist_out_q;
	assign cell_label   = lab_out_q;
	assign w0           = w_out_q[15:0];
	assign w1           = w_out_q[31:16];
	assign w2           = w_out_q[47:32];
	assign w3           = w_out_q[63:48];

	`SOM_ASSERT_IMP(a_upd_has_rate, state_q == ST_UPD, div_done, "update without rate")
	`SOM_ASSERT_IMP(a_upd_rows, state_q == ST_UPD, upd_row_ok, "update row outside neighborhood")
	`SOM_ASSERT_NXT(a_fout_done, state_q == ST_FOUT, done_q && (state_q == ST_IDLE), "no result")
	`SOM_ASSERT_IMP(a_ctl_excl, ctl_q.upd || ctl_q.srch, !ctl_q.ld_en && !ctl_q.lab_en, "write")

endmodule

>>> rtl/som_div.sv
// Learning rate unit: one multiply, then a bit-serial restoring divide; rate is zero once epoch >= ecount.
module som_div import som_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] base,
	input  logic [WORD_W-1:0] ecount,
	input  logic [WORD_W-1:0] epoch,
	output logic [WORD_W-1:0] rate,
	output logic              done
);

	typedef enum logic {D_IDLE, D_RUN} dstate_t;

	dstate_t           state_q;
	logic [31:0]       num_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] den_q;
	logic [4:0]        cnt_q;
	logic              done_q;
	logic [WORD_W:0]   rem2;

	assign rem2 = {rem_q, num_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			num_q   <= '0;
			rem_q   <= '0;
			den_q   <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						rem_q <= '0;
						den_q <= ecount;
						cnt_q <= '0;
						if (epoch >= ecount) begin
							num_q  <= '0;
							done_q <= 1'b1;
						end else begin
							num_q   <= 32'(base) * 32'(ecount - epoch);
							done_q  <= 1'b0;
							state_q <= D_RUN;
						end
					end
				end
				D_RUN: begin
					if (rem2 >= {1'b0, den_q}) begin
						rem_q <= WORD_W'(rem2 - {1'b0, den_q});
						num_q <= {num_q[30:0], 1'b1};
					end else begin
						rem_q <= rem2[WORD_W-1:0];
						num_q <= {num_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign rate = num_q[WORD_W-1:0];
	assign done = done_q;

endmodule

>>> rtl/som_cell.sv
// One grid column: weight rows, labels, distance and update datapath, min chain link.
module som_cell import som_pkg::*; #(
	parameter int ROWS = 8,
	parameter int RW   = 3,
	parameter int CW   = 4,
	parameter int COL  = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [RW-1:0]     rd_row,
	input  logic [RW-1:0]     wr_row,
	input  logic [CW-1:0]     sel_col,
	input  logic [CW-1:0]     col_lo,
	input  logic [CW-1:0]     col_hi,
	input  logic [VEC_W-1:0]  x,
	input  logic [WORD_W-1:0] rate,
	input  logic [1:0]        cls,
	input  chain_t            ch_in,
	output chain_t            ch_out,
	output logic [VEC_W-1:0]  rdata,
	output logic [1:0]        rlab
);

	logic [VEC_W-1:0]  mem [ROWS];
	logic [1:0]        lab_q [ROWS];
	logic [ROWS-1:0]   seen_q;
	logic [VEC_W-1:0]  rdata_q;
	logic [1:0]        rlab_q;
	logic              srch_s1, upd_s1, srch_s2, upd_s2, srch_s3;
	logic [RW-1:0]     row_s1, row_s2, row_s3;
	logic [SQ_W-1:0]   sq_s2 [4];
	logic [32:0]       pa_s2 [4];
	logic [31:0]       pb_s2 [4];
	logic [DIST_W-1:0] d_s3;
	logic              have_q;
	logic [DIST_W-1:0] best_d_q;
	logic [RW-1:0]     best_r_q;
	chain_t            ch_q;
	logic [CW-1:0]     my_col;
	logic              sel_hit, in_rng, take_local;
	logic [VEC_W-1:0]  new_vec;
	logic [16:0]       inv;

	assign my_col  = CW'(COL);
	assign sel_hit = (sel_col == my_col);
	assign in_rng  = (my_col >= col_lo) && (my_col <= col_hi);
	assign inv     = 17'h10000 - {1'b0, rate};

	always_comb begin
		logic [33:0] acc;
		new_vec = '0;
		for (int k = 0; k < 4; k++) begin
			acc = 34'(pa_s2[k]) + 34'(pb_s2[k]) + 34'd32768;
			new_vec[k*WORD_W +: WORD_W] = acc[31:16];
		end
	end

	always_ff @(posedge clk) begin
		if (upd_s2 && in_rng) begin
			mem[row_s2] <= new_vec;
		end else if (ctl.ld_en && sel_hit) begin
			mem[wr_row] <= x;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[rd_row];
			rlab_q  <= lab_q[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srch_s1 <= 1'b0;
			upd_s1  <= 1'b0;
			srch_s2 <= 1'b0;
			upd_s2  <= 1'b0;
			srch_s3 <= 1'b0;
		end else begin
			srch_s1 <= ctl.rd_en && ctl.srch;
			upd_s1  <= ctl.rd_en && ctl.upd;
			srch_s2 <= srch_s1;
			upd_s2  <= upd_s1;
			srch_s3 <= srch_s2;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [16:0] diff;
		logic [WORD_W-1:0]  w, xk;
		row_s1 <= rd_row;
		row_s2 <= row_s1;
		row_s3 <= row_s2;
		for (int k = 0; k < 4; k++) begin
			w        = rdata_q[k*WORD_W +: WORD_W];
			xk       = x[k*WORD_W +: WORD_W];
			diff     = $signed({1'b0, w}) - $signed({1'b0, xk});
			sq_s2[k] <= SQ_W'(diff * diff);
			pa_s2[k] <= {17'b0, w} * {16'b0, inv};
			pb_s2[k] <= 32'(xk) * 32'(rate);
		end
		d_s3 <= DIST_W'(sq_s2[0]) + DIST_W'(sq_s2[1]) + DIST_W'(sq_s2[2])
			+ DIST_W'(sq_s2[3]);
	end

	assign take_local = have_q && (!ch_in.v || (best_d_q < ch_in.d)
		|| ((best_d_q == ch_in.d) && (IDX_W'(best_r_q) < ch_in.r)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q   <= 1'b0;
			best_d_q <= '0;
			best_r_q <= '0;
			ch_q     <= '0;
		end else begin
			if (ctl.first) begin
				have_q <= 1'b0;
			end else if (srch_s3 && (!have_q || d_s3 < best_d_q)) begin
				have_q   <= 1'b1;
				best_d_q <= d_s3;
				best_r_q <= row_s3;
			end
			if (take_local) begin
				ch_q <= '{v: 1'b1, d: best_d_q, r: IDX_W'(best_r_q), c: IDX_W'(COL)};
			end else begin
				ch_q <= ch_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int i = 0; i < ROWS; i++) lab_q[i] <= 2'd0;
		end else if (ctl.clr) begin
			seen_q <= '0;
			for (int i = 0; i < ROWS; i++) lab_q[i] <= 2'd0;
		end else if (ctl.lab_en && sel_hit && !seen_q[wr_row]) begin
			seen_q[wr_row] <= 1'b1;
			lab_q[wr_row]  <= cls;
		end
	end

	assign ch_out = ch_q;
	assign rdata  = rdata_q;
	assign rlab   = rlab_q;

endmodule

>>> test/som_bmu_search_and_update_core_tb.sv
// Self-checking testbench for the map core: directed table, then random requests per phase.
`timescale 1ns / 1ps
module som_bmu_search_and_update_core_tb;
	import som_pkg::*;

	localparam logic [2:0] FN_SPARE5 = 3'd5;
	localparam logic [2:0] FN_SPARE6 = 3'd6;
	localparam logic [2:0] FN_SPARE7 = 3'd7;
	localparam int ROWS = 8;
	localparam int COLS = 16;
	localparam int CELLS = ROWS * COLS;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int PHASE_ITEMS = 172;

	typedef struct {
		logic [2:0]  func;
		logic [15:0] x [4];
		logic [15:0] epoch;
		logic [2:0]  row;
		logic [3:0]  col;
		logic [1:0]  cls;
	} request_t;

	typedef struct {
		logic [2:0]  row;
		logic [3:0]  col;
		logic [33:0] dsq;
		logic [1:0]  lab;
		logic [15:0] w [4];
	} cell_report_t;

	typedef struct {
		request_t     req;
		bit           typed;
		cell_report_t want;
	} table_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done;
	logic cfg_we = 0;
	logic [1:0] cfg_idx = '0;
	logic [15:0] cfg_wdata = '0;
	logic [2:0] func = '0;
	logic [15:0] x0 = '0, x1 = '0, x2 = '0, x3 = '0, epoch = '0;
	logic [2:0] cell_row = '0;
	logic [3:0] cell_col = '0;
	logic [1:0] class_id = '0;
	logic [2:0] bmu_row;
	logic [3:0] bmu_col;
	logic [33:0] best_dist_sq;
	logic [1:0] cell_label;
	logic [15:0] w0, w1, w2, w3;

	som_bmu_search_and_update_core dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	bit [15:0] map_wt [CELLS][4];
	bit [1:0]  map_lab [CELLS];
	bit        map_seen [CELLS];
	bit [15:0] rate_base_q = 16'd58982;
	bit [15:0] epoch_count_q = 16'd500;
	bit [3:0]  radius_q = 4'd3;

	cell_report_t pending_results[$];
	int fails = 0;
	int cycles = 0;
	bit quiet_phase;

	function automatic cell_report_t zero_report();
		cell_report_t z;
		z.row = '0; z.col = '0; z.dsq = '0; z.lab = '0;
		for (int k = 0; k < 4; k++) z.w[k] = '0;
		return z;
	endfunction

	function automatic cell_report_t som_apply(request_t q);
		cell_report_t o;
		longint unsigned best, d, rate, v;
		longint diff;
		int br, bc, idx, rad;
		o = zero_report();
		case (q.func)
			FN_LOAD, FN_READ: begin
				idx = q.row * COLS + q.col;
				if (q.func == FN_LOAD)
					for (int k = 0; k < 4; k++) map_wt[idx][k] = q.x[k];
				o.row = q.row; o.col = q.col; o.lab = map_lab[idx];
				for (int k = 0; k < 4; k++) o.w[k] = map_wt[idx][k];
			end
			FN_TRAIN, FN_LABEL: begin
				best = 0; br = 0; bc = 0;
				for (int i = 0; i < CELLS; i++) begin
					d = 0;
					for (int k = 0; k < 4; k++) begin
						diff = longint'(map_wt[i][k]) - longint'(q.x[k]);
						d += diff * diff;
					end
					if (i == 0 || d < best) begin
						best = d; br = i / COLS; bc = i % COLS;
					end
				end
				idx = br * COLS + bc;
				if (q.func == FN_TRAIN) begin
					rate = 0;
					rad = int'(radius_q);
					if (q.epoch < epoch_count_q)
						rate = (64'(rate_base_q) * (epoch_count_q - q.epoch)) / epoch_count_q;
					for (int r = br - rad; r <= br + rad; r++)
						for (int c = bc - rad; c <= bc + rad; c++)
							if (r >= 0 && r < ROWS && c >= 0 && c < COLS)
								for (int k = 0; k < 4; k++) begin
									v = (64'(map_wt[r * COLS + c][k]) * (65536 - rate)
										+ 64'(q.x[k]) * rate + 32768) >> 16;
									map_wt[r * COLS + c][k] = v[15:0];
								end
				end else if (!map_seen[idx]) begin
					map_lab[idx] = q.cls;
					map_seen[idx] = 1;
				end
				o.row = 3'(br); o.col = 4'(bc); o.dsq = 34'(best); o.lab = map_lab[idx];
				for (int k = 0; k < 4; k++) o.w[k] = map_wt[idx][k];
			end
			FN_CLEAR: begin
				for (int i = 0; i < CELLS; i++) begin
					map_lab[i] = 0; map_seen[i] = 0;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		cell_report_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				fails++;
			end else begin
				e = pending_results.pop_front();
				if (bmu_row !== e.row) begin
					$error("bmu_row exp %0d got %0d", e.row, bmu_row); fails++;
				end
				if (bmu_col !== e.col) begin
					$error("bmu_col exp %0d got %0d", e.col, bmu_col); fails++;
				end
				if (best_dist_sq !== e.dsq) begin
					$error("best_dist_sq exp %0d got %0d", e.dsq, best_dist_sq); fails++;
				end
				if (cell_label !== e.lab) begin
					$error("cell_label exp %0d got %0d", e.lab, cell_label); fails++;
				end
				if (w0 !== e.w[0]) begin
					$error("w0 exp %0h got %0h", e.w[0], w0); fails++;
				end
				if (w1 !== e.w[1]) begin
					$error("w1 exp %0h got %0h", e.w[1], w1); fails++;
				end
				if (w2 !== e.w[2]) begin
					$error("w2 exp %0h got %0h", e.w[2], w2); fails++;
				end
				if (w3 !== e.w[3]) begin
					$error("w3 exp %0h got %0h", e.w[3], w3); fails++;
				end
			end
		end
	end

	// drive at the current edge, hold until accepted
	task automatic send_request(request_t q, bit typed, cell_report_t want);
		cell_report_t p;
		func <= q.func; x0 <= q.x[0]; x1 <= q.x[1]; x2 <= q.x[2]; x3 <= q.x[3];
		epoch <= q.epoch; cell_row <= q.row; cell_col <= q.col; class_id <= q.cls;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		p = som_apply(q);
		pending_results.push_back(typed ? want : p);
	endtask

	task automatic idle_gap();
		int r, g;
		r = $urandom_range(0, 9);
		g = 0;
		if (!quiet_phase) begin
			if (r >= 5 && r < 9) g = $urandom_range(1, 3);
			else if (r == 9) g = $urandom_range(8, 40);
		end
		if (g > 0) begin
			start <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_config(bit [15:0] rb, bit [15:0] ec, bit [3:0] rad);
		cfg_we <= 1; cfg_idx <= CFG_RATE_BASE; cfg_wdata <= rb;
		@(posedge clk);
		rate_base_q = rb;
		cfg_idx <= CFG_EPOCH_COUNT; cfg_wdata <= ec;
		@(posedge clk);
		epoch_count_q = ec;
		cfg_idx <= CFG_RADIUS; cfg_wdata <= 16'(rad);
		@(posedge clk);
		radius_q = rad;
		cfg_we <= 0;
		@(posedge clk);
	endtask

	function automatic request_t make_request(logic [2:0] f, logic [15:0] a, logic [15:0] b,
		logic [15:0] c, logic [15:0] d, logic [15:0] ep, logic [2:0] r, logic [3:0] cl,
		logic [1:0] cs);
		request_t q;
		q.func = f; q.x[0] = a; q.x[1] = b; q.x[2] = c; q.x[3] = d;
		q.epoch = ep; q.row = r; q.col = cl; q.cls = cs;
		return q;
	endfunction

	function automatic logic [15:0] rand_word();
		int s;
		s = $urandom_range(0, 15);
		if (s == 0) return 16'h0000;
		if (s == 1) return 16'hFFFF;
		return 16'($urandom);
	endfunction

	function automatic request_t random_request();
		request_t q;
		int s;
		q = make_request(FN_TRAIN, rand_word(), rand_word(), rand_word(), rand_word(),
			16'($urandom), 3'($urandom), 4'($urandom), 2'($urandom));
		if (epoch_count_q != 0 && $urandom_range(0, 9) < 7)
			q.epoch = 16'($urandom_range(0, epoch_count_q - 1));
		s = $urandom_range(0, 99);
		if (s < 55) q.func = FN_TRAIN;
		else if (s < 72) q.func = FN_LABEL;
		else if (s < 84) q.func = FN_LOAD;
		else if (s < 95) q.func = FN_READ;
		else if (s < 97) q.func = FN_CLEAR;
		else q.func = 3'($urandom_range(5, 7));
		return q;
	endfunction

	table_row_t stim_table[$];

	task automatic add_row(request_t q, bit typed, cell_report_t want);
		table_row_t t;
		t.req = q; t.typed = typed; t.want = want;
		stim_table.push_back(t);
	endtask

	initial begin
		cell_report_t z, hi, lo;
		request_t q;
		bit [15:0] settings [6][3];
		settings = '{'{16'hFFFF, 16'd1, 16'd0}, '{16'd0, 16'hFFFF, 16'd15},
			'{16'd30000, 16'd0, 16'd7}, '{16'd58982, 16'd500, 16'd3},
			'{16'd12345, 16'd200, 16'd1}, '{16'hFFFF, 16'hFFFF, 16'd15}};
		for (int i = 0; i < CELLS; i++) begin
			map_lab[i] = 0; map_seen[i] = 0;
		end
		z = zero_report();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// fill every cell before any search
		for (int i = 0; i < CELLS; i++) begin
			q = make_request(FN_LOAD, rand_word(), rand_word(), rand_word(), rand_word(),
				16'($urandom), 3'(i / COLS), 4'(i % COLS), 2'($urandom));
			send_request(q, 0, z);
			idle_gap();
		end

		lo = z; lo.row = 3'd0; lo.col = 4'd0;
		hi = z; hi.row = 3'd7; hi.col = 4'd15;
		for (int k = 0; k < 4; k++) hi.w[k] = 16'hFFFF;
		add_row(make_request(FN_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			3'd7, 4'd15, 2'd3), 1, z);
		add_row(make_request(FN_SPARE5, 16'h1234, 0, 0, 0, 0, 3'd2, 4'd3, 2'd1), 1, z);
		add_row(make_request(FN_SPARE6, 0, 0, 0, 0, 0, 3'd1, 4'd1, 2'd2), 1, z);
		add_row(make_request(FN_SPARE7, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF, 3'd7, 4'd15,
			2'd3), 1, z);
		add_row(make_request(FN_LOAD, 0, 0, 0, 0, 0, 3'd0, 4'd0, 2'd0), 1, lo);
		add_row(make_request(FN_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			3'd7, 4'd15, 2'd3), 1, hi);
		add_row(make_request(FN_READ, 16'hFFFF, 0, 0, 0, 0, 3'd0, 4'd0, 2'd0), 1, lo);
		add_row(make_request(FN_READ, 0, 0, 0, 0, 0, 3'd7, 4'd15, 2'd0), 1, hi);
		add_row(make_request(FN_LABEL, 0, 0, 0, 0, 0, 3'd0, 4'd0, 2'd1), 0, z);
		add_row(make_request(FN_LABEL, 0, 0, 0, 0, 0, 3'd0, 4'd0, 2'd2), 0, z);
		add_row(make_request(FN_LABEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 3'd0,
			4'd0, 2'd0), 0, z);
		add_row(make_request(FN_LABEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 3'd0,
			4'd0, 2'd3), 0, z);
		add_row(make_request(FN_TRAIN, 0, 0, 0, 0, 0, 3'd0, 4'd0, 2'd0), 0, z);
		add_row(make_request(FN_TRAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd499,
			3'd0, 4'd0, 2'd0), 0, z);
		add_row(make_request(FN_TRAIN, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'd500,
			3'd0, 4'd0, 2'd0), 0, z);
		add_row(make_request(FN_TRAIN, 16'h7FFF, 16'h0001, 16'hFFFE, 16'h8000, 16'hFFFF,
			3'd0, 4'd0, 2'd0), 0, z);
		add_row(make_request(FN_CLEAR, 0, 0, 0, 0, 0, 3'd0, 4'd0, 2'd0), 1, z);
		add_row(make_request(FN_READ, 0, 0, 0, 0, 0, 3'd7, 4'd15, 2'd0), 0, z);
		add_row(make_request(FN_LABEL, 0, 0, 0, 0, 0, 3'd0, 4'd0, 2'd2), 0, z);
		add_row(make_request(FN_READ, 0, 0, 0, 0, 0, 3'd0, 4'd0, 2'd0), 0, z);
		foreach (stim_table[i]) begin
			send_request(stim_table[i].req, stim_table[i].typed, stim_table[i].want);
			idle_gap();
		end

		quiet_phase = 0;
		for (int p = 0; p <= 6; p++) begin
			if (p > 0) begin
				drain();
				write_config(settings[p-1][0], settings[p-1][1], 4'(settings[p-1][2]));
				quiet_phase = ($urandom_range(0, 9) < 3);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_request(random_request(), 0, z);
				idle_gap();
			end
		end

		start <= 0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
